// ===== rtl/euler_angles_to_rotation_matrix_top_defines.svh =====
// Assertion macros shared by the checker of the rotation matrix block.
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define EAR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define EAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/ear_pkg.sv =====
// Types and constants of the rotation matrix block.
package ear_pkg;
    localparam int CordicSteps = 30;
    localparam int CordicW = 34;
    localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

    typedef logic signed [CordicW-1:0] t_cw;
    typedef logic signed [15:0] t_q;

    typedef struct packed {
        t_q m00; t_q m01; t_q m02;
        t_q m10; t_q m11; t_q m12;
        t_q m20; t_q m21; t_q m22;
    } t_mat;

    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
            27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction
endpackage

// ===== rtl/ear_stream_if.sv =====
// Valid/ready stream interface with a generic payload.
interface ear_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ear_cordic_cell.sv =====
// One CORDIC micro-rotation cell for the three angles, registered.
module ear_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  ear_pkg::t_cw [2:0]   i_x,
    input  ear_pkg::t_cw [2:0]   i_y,
    input  ear_pkg::t_cw [2:0]   i_z,
    input  logic [2:0][1:0]      i_quad,
    output ear_pkg::t_cw [2:0]   o_x,
    output ear_pkg::t_cw [2:0]   o_y,
    output ear_pkg::t_cw [2:0]   o_z,
    output logic [2:0][1:0]      o_quad
);
    import ear_pkg::*;
    localparam t_cw Atan = t_cw'(atan_step(STEP));
    t_cw [2:0] n_x, n_y, n_z;
    t_cw [2:0] r_x, r_y, r_z;
    logic [2:0][1:0] r_quad;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_z[k][CordicW-1]) begin
                n_x[k] = i_x[k] - (i_y[k] >>> STEP);
                n_y[k] = i_y[k] + (i_x[k] >>> STEP);
                n_z[k] = i_z[k] - Atan;
            end else begin
                n_x[k] = i_x[k] + (i_y[k] >>> STEP);
                n_y[k] = i_y[k] - (i_x[k] >>> STEP);
                n_z[k] = i_z[k] + Atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_quad <= i_quad;
        end
    end
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_quad = r_quad;
endmodule

// ===== rtl/ear_matrix.sv =====
// Rounds the CORDIC outputs and forms the nine matrix entries over three stages.
module ear_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  ear_pkg::t_cw [2:0] i_x,
    input  ear_pkg::t_cw [2:0] i_y,
    input  logic [2:0][1:0]    i_quad,
    output ear_pkg::t_mat      o_mat
);
    import ear_pkg::*;
    localparam int Drop = 30 - FRAC_BITS;
    localparam int VW = FRAC_BITS + 2;
    localparam int PW = 2 * VW + 2;
    typedef logic signed [VW-1:0] t_v;
    typedef logic signed [PW-1:0] t_p;
    localparam t_cw One = t_cw'(1) <<< FRAC_BITS;
    localparam t_p POne = t_p'(1) <<< FRAC_BITS;

    function automatic t_v sat_c(input t_cw v);
        t_cw r;
        r = (v + (t_cw'(1) <<< (Drop - 1))) >>> Drop;
        if (r > One) r = One;
        else if (r < -One) r = -One;
        return t_v'(r);
    endfunction

    function automatic t_p fin(input t_p w);
        t_p r;
        r = (w + (t_p'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > POne) r = POne;
        else if (r < -POne) r = -POne;
        return r;
    endfunction

    // Stage 1: rounded sine and cosine with quadrant fold.
    t_v [2:0] r_s, r_c;
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 3; k++) begin
                case (i_quad[k])
                    2'd0: begin r_c[k] <= sat_c(i_x[k]);  r_s[k] <= sat_c(i_y[k]);  end
                    2'd1: begin r_c[k] <= -sat_c(i_y[k]); r_s[k] <= sat_c(i_x[k]);  end
                    2'd2: begin r_c[k] <= -sat_c(i_x[k]); r_s[k] <= -sat_c(i_y[k]); end
                    default: begin r_c[k] <= sat_c(i_y[k]); r_s[k] <= -sat_c(i_x[k]); end
                endcase
            end
        end
    end

    // Stage 2: two-factor products; the z*x ones are rounded for the triple terms.
    t_p r_szsx, r_czsx, r_szcx, r_czcx, r_cxsy, r_cxcy, r_nsx;
    t_v r_sy, r_cy, r_sz, r_cz;
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_szsx <= fin(t_p'(r_s[2]) * t_p'(r_s[0]));
            r_czsx <= fin(t_p'(r_c[2]) * t_p'(r_s[0]));
            r_szcx <= fin(t_p'(r_s[2]) * t_p'(r_c[0]));
            r_czcx <= fin(t_p'(r_c[2]) * t_p'(r_c[0]));
            r_cxsy <= fin(t_p'(r_c[0]) * t_p'(r_s[1]));
            r_cxcy <= fin(t_p'(r_c[0]) * t_p'(r_c[1]));
            r_nsx <= -t_p'(r_s[0]);
            r_sy <= r_s[1]; r_cy <= r_c[1]; r_sz <= r_s[2]; r_cz <= r_c[2];
        end
    end

    // Stage 3: sums of products for the remaining entries.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_mat.m00 <= t_q'(fin(r_szsx * t_p'(r_sy) + t_p'(r_cz) * t_p'(r_cy)));
            o_mat.m02 <= t_q'(fin(r_szsx * t_p'(r_cy) - t_p'(r_cz) * t_p'(r_sy)));
            o_mat.m10 <= t_q'(fin(r_czsx * t_p'(r_sy) - t_p'(r_sz) * t_p'(r_cy)));
            o_mat.m12 <= t_q'(fin(r_czsx * t_p'(r_cy) + t_p'(r_sz) * t_p'(r_sy)));
            o_mat.m01 <= t_q'(r_szcx);
            o_mat.m11 <= t_q'(r_czcx);
            o_mat.m20 <= t_q'(r_cxsy);
            o_mat.m21 <= t_q'(r_nsx);
            o_mat.m22 <= t_q'(r_cxcy);
        end
    end
endmodule

// ===== rtl/euler_angles_to_rotation_matrix_top.sv =====
// Top level of the Euler angle (Z-X-Y) to rotation matrix pipeline.
//
// Usage: the input channel carries one request of three signed binary
// angles (x, y, z); the output channel returns the nine Q1.14 entries
// of the rotation matrix in row order, one result per request.
// The datapath is a row of thirty CORDIC cells, one micro-rotation
// each, followed by a rounding stage, a product stage and a sum stage.
// An angle scaling register stands before the cell row.
// Throughput is one request per cycle unless the receiver stalls;
// it is set by the cell row, each stage holding a different request.
// The whole pipeline advances together: when the receiver stalls with
// a valid result waiting, every stage holds and input ready drops, so
// no request is lost. While the output stage is empty or being taken,
// ready stays high even if earlier requests are in flight.
// Reset clears only the stage valid bits; the payload is not reset.
module euler_angles_to_rotation_matrix_top #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input logic i_clk,
    input logic i_rst_n,
    ear_stream_if.sink   i_req,
    ear_stream_if.source o_rsp
);
    import ear_pkg::*;
    localparam int Stages = 1 + CordicSteps + 3;

    logic adv;
    logic [Stages-1:0] r_vld;
    assign adv = !r_vld[Stages-1] || o_rsp.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[Stages-2:0], i_req.valid};
        end
    end

    // Angle scaling to 32 bits per turn and quadrant split.
    logic [2:0][ANGLE_BITS-1:0] ang;
    t_cw [2:0] r_x0, r_y0, r_z0;
    logic [2:0][1:0] r_q0;
    assign ang[0] = ANGLE_BITS'(i_req.data[47:32]);
    assign ang[1] = ANGLE_BITS'(i_req.data[31:16]);
    assign ang[2] = ANGLE_BITS'(i_req.data[15:0]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                logic [31:0] a32;
                a32 = 32'(ang[k]) << (32 - ANGLE_BITS);
                r_q0[k] <= a32[31:30];
                r_z0[k] <= t_cw'({2'b00, a32[29:0]});
                r_x0[k] <= CordicGain;
                r_y0[k] <= '0;
            end
        end
    end

    t_cw [CordicSteps:0][2:0] cx, cy, cz;
    logic [CordicSteps:0][2:0][1:0] cq;
    assign cx[0] = r_x0;
    assign cy[0] = r_y0;
    assign cz[0] = r_z0;
    assign cq[0] = r_q0;

    for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
        ear_cordic_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_x(cx[g]), .i_y(cy[g]), .i_z(cz[g]), .i_quad(cq[g]),
            .o_x(cx[g+1]), .o_y(cy[g+1]), .o_z(cz[g+1]), .o_quad(cq[g+1])
        );
    end

    t_mat mat;
    ear_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk(i_clk), .i_en({3{adv}}),
        .i_x(cx[CordicSteps]), .i_y(cy[CordicSteps]), .i_quad(cq[CordicSteps]),
        .o_mat(mat)
    );

    assign o_rsp.valid = r_vld[Stages-1];
    assign o_rsp.data = mat;
endmodule

// ===== rtl/ear_checker.sv =====
// Port checker for the rotation matrix block, bound to the top level.
`include "euler_angles_to_rotation_matrix_top_defines.svh"
module ear_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [143:0] i_out_data
);
    `EAR_ASSERT_IMPL(a_ready_when_free, i_clk, i_rst_n, !i_out_valid, i_in_ready, "ready low with empty output")
    `EAR_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready, "ready high during stall")
    `EAR_ASSERT_IMPL(a_take_frees, i_clk, i_rst_n, i_in_valid && i_out_valid && i_out_ready, i_in_ready, "input blocked")
    `EAR_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data) && i_out_valid, "stalled result changed")
endmodule

bind euler_angles_to_rotation_matrix_top ear_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
    .i_out_data(o_rsp.data)
);
